/* rtl/lrucache_pkg.sv */
// shared types, codes and defaults for the lru set-associative tag store
package lrucache_pkg;

  // default geometry
  localparam int MaxSetsDef = 1024;
  localparam int MaxWaysDef = 8;

  // configuration register indexes
  localparam logic [1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [1:0] CFG_OFFSET_BITS = 2'd1;
  localparam logic [1:0] CFG_WAYS        = 2'd2;

  // access commands
  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_STORE  = 2'd1,
    CMD_MODIFY = 2'd2,
    CMD_NONE   = 2'd3
  } command_e;

  // lookup outcomes
  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_e;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_COMMIT,
    ST_REREAD
  } state_e;

  // input item
  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] address;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [1:0]  outcome;
    logic [9:0]  set_index;
    logic [2:0]  way_used;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] eviction_total;
    logic        last;
  } out_item_t;

  // one way of a set row
  typedef struct packed {
    logic        valid;
    logic [63:0] tag;
    logic [31:0] stamp;
  } line_t;

  // controller to datapath
  typedef struct packed {
    logic clear_step;
    logic take;
    logic reread;
    logic eval;
    logic commit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic in_noop;
    logic out_free;
    logic more;
  } ctrl_status_t;

endpackage

/* rtl/lrucache_ctrl.sv */
// sequencer for the tag store: clearing pass, lookup read, evaluate, write-back
module lrucache_ctrl
  import lrucache_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  ctrl_status_t status_i,
  output ctrl_cmd_t    cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (status_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i && !status_i.in_noop) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (status_i.out_free) begin
          state_d = status_i.more ? ST_REREAD : ST_IDLE;
        end
      end
      ST_REREAD: begin
        state_d = ST_EVAL;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clear_step = 1'b1;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      ST_EVAL:   cmd_o.eval = 1'b1;
      ST_COMMIT: cmd_o.commit = status_i.out_free;
      ST_REREAD: cmd_o.reread = 1'b1;
      default: cmd_o = '0;
    endcase
  end

endmodule

/* rtl/lrucache_dp.sv */
// datapath: config registers, set row memory, way selection, totals, result register
module lrucache_dp
  import lrucache_pkg::*;
#(
  parameter int MAX_SETS = MaxSetsDef,
  parameter int MAX_WAYS = MaxWaysDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [5:0]   cfg_wdata_i,
  input  in_item_t     in_item_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output out_item_t    out_item_o,
  input  ctrl_cmd_t    cmd_i,
  output ctrl_status_t status_o
);

  localparam int SetAw = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WayAw = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  // largest k with 2^k <= MAX_SETS
  localparam int SetK  = $clog2(MAX_SETS + 1) - 1;
  localparam int Lv    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 0;
  localparam int Pad   = 1 << Lv;

  typedef line_t [MAX_WAYS-1:0] row_t;

  // configuration registers
  logic [3:0] set_bits_q;
  logic [5:0] offset_bits_q;
  logic [3:0] ways_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q    <= '0;
      offset_bits_q <= '0;
      ways_q        <= 4'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SET_BITS:    set_bits_q    <= cfg_wdata_i[3:0];
        CFG_OFFSET_BITS: offset_bits_q <= cfg_wdata_i;
        CFG_WAYS:        ways_q        <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // clamp set bits and way count
  logic [4:0] sb_eff;
  logic [5:0] ways_eff;

  always_comb begin
    sb_eff = {1'b0, set_bits_q};
    if (sb_eff > 5'(SetK)) sb_eff = 5'(SetK);
    ways_eff = 6'(ways_q);
    if (ways_eff == 6'd0) begin
      ways_eff = 6'd1;
    end else if (ways_eff > 6'(MAX_WAYS)) begin
      ways_eff = 6'(MAX_WAYS);
    end
  end

  // split the incoming address; shifts of 64 or more give zero
  logic [63:0]      shifted;
  logic [63:0]      set_mask;
  logic [63:0]      set_full;
  logic [63:0]      tag_now;
  logic [SetAw-1:0] set_now;

  assign shifted  = in_item_i.address >> offset_bits_q;
  assign set_mask = (64'd1 << sb_eff) - 64'd1;
  assign set_full = shifted & set_mask;
  assign set_now  = set_full[SetAw-1:0];
  assign tag_now  = in_item_i.address >> (7'(offset_bits_q) + 7'(sb_eff));

  // item context
  logic [SetAw-1:0] set_q;
  logic [63:0]      tag_q;
  logic             modify_q;
  logic             second_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      set_q <= set_now;
      tag_q <= tag_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modify_q <= 1'b0;
      second_q <= 1'b0;
    end else if (cmd_i.take) begin
      modify_q <= (command_e'(in_item_i.command) == CMD_MODIFY);
      second_q <= 1'b0;
    end else if (cmd_i.commit && modify_q && !second_q) begin
      second_q <= 1'b1;
    end
  end

  // clearing pass counter
  logic [SetAw-1:0] clr_cnt_q;
  logic             clear_last;

  assign clear_last = (clr_cnt_q == SetAw'(MAX_SETS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear_step && !clear_last) begin
      clr_cnt_q <= clr_cnt_q + SetAw'(1);
    end
  end

  // set row memory, one row per set
  row_t             mem [MAX_SETS];
  row_t             rd_row_q;
  row_t             wr_row;
  logic             rd_en;
  logic [SetAw-1:0] rd_addr;
  logic             wr_en;
  logic [SetAw-1:0] wr_addr;

  assign rd_en   = cmd_i.take || cmd_i.reread;
  assign rd_addr = cmd_i.take ? set_now : set_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_row;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rd_row_q <= mem[rd_addr];
  end

  // hit and free-way search over the row
  logic [MAX_WAYS-1:0] in_use;
  logic [MAX_WAYS-1:0] hit_vec;
  logic [MAX_WAYS-1:0] free_vec;
  logic [WayAw-1:0]    hit_way;
  logic [WayAw-1:0]    free_way;

  always_comb begin
    hit_way  = '0;
    free_way = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w]   = (6'(w) < ways_eff);
      hit_vec[w]  = in_use[w] && rd_row_q[w].valid && (rd_row_q[w].tag == tag_q);
      free_vec[w] = in_use[w] && !rd_row_q[w].valid;
    end
    // lowest set bit wins
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w])  hit_way  = WayAw'(w);
      if (free_vec[w]) free_way = WayAw'(w);
    end
  end

  // oldest stamp via a comparison tree, lower way wins a tie
  logic [31:0]      t_stamp [Lv+1][Pad];
  logic [WayAw-1:0] t_idx   [Lv+1][Pad];
  logic             t_use   [Lv+1][Pad];
  logic [WayAw-1:0] old_way;

  always_comb begin
    for (int l = 0; l <= Lv; l++) begin
      for (int i = 0; i < Pad; i++) begin
        t_stamp[l][i] = '0;
        t_idx[l][i]   = '0;
        t_use[l][i]   = 1'b0;
      end
    end
    for (int i = 0; i < MAX_WAYS; i++) begin
      t_stamp[0][i] = rd_row_q[i].stamp;
      t_idx[0][i]   = WayAw'(i);
      t_use[0][i]   = in_use[i];
    end
    for (int l = 0; l < Lv; l++) begin
      for (int i = 0; i < (Pad >> (l + 1)); i++) begin
        if (t_use[l][2*i+1] &&
            (!t_use[l][2*i] || (t_stamp[l][2*i+1] < t_stamp[l][2*i]))) begin
          t_stamp[l+1][i] = t_stamp[l][2*i+1];
          t_idx[l+1][i]   = t_idx[l][2*i+1];
        end else begin
          t_stamp[l+1][i] = t_stamp[l][2*i];
          t_idx[l+1][i]   = t_idx[l][2*i];
        end
        t_use[l+1][i] = t_use[l][2*i] || t_use[l][2*i+1];
      end
    end
    old_way = t_idx[Lv][0];
  end

  // evaluate result
  outcome_e         outcome_q;
  logic [WayAw-1:0] pick_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      if (|hit_vec) begin
        outcome_q <= OUT_HIT;
        pick_q    <= hit_way;
      end else if (|free_vec) begin
        outcome_q <= OUT_FILL;
        pick_q    <= free_way;
      end else begin
        outcome_q <= OUT_EVICT;
        pick_q    <= old_way;
      end
    end
  end

  // stamp counter and saturating totals
  logic [31:0] stamp_q, stamp_d;
  logic [31:0] hits_q, hits_d;
  logic [31:0] misses_q, misses_d;
  logic [31:0] evicts_q, evicts_d;

  always_comb begin
    stamp_d  = stamp_q + 32'd1;
    hits_d   = hits_q;
    misses_d = misses_q;
    evicts_d = evicts_q;
    if (outcome_q == OUT_HIT) begin
      if (hits_q != '1) hits_d = hits_q + 32'd1;
    end else begin
      if (misses_q != '1) misses_d = misses_q + 32'd1;
    end
    if (outcome_q == OUT_EVICT && evicts_q != '1) evicts_d = evicts_q + 32'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stamp_q  <= '0;
      hits_q   <= '0;
      misses_q <= '0;
      evicts_q <= '0;
    end else if (cmd_i.commit) begin
      stamp_q  <= stamp_d;
      hits_q   <= hits_d;
      misses_q <= misses_d;
      evicts_q <= evicts_d;
    end
  end

  // write-back row: clearing pass or updated way
  always_comb begin
    wr_en   = cmd_i.clear_step || cmd_i.commit;
    wr_addr = cmd_i.clear_step ? clr_cnt_q : set_q;
    if (cmd_i.clear_step) begin
      wr_row = '0;
    end else begin
      wr_row = rd_row_q;
      wr_row[pick_q].valid = 1'b1;
      wr_row[pick_q].tag   = tag_q;
      wr_row[pick_q].stamp = stamp_d;
    end
  end

  // result register
  logic        out_valid_q;
  out_item_t   out_item_q;
  logic        out_free;
  logic [63:0] set_ext;
  logic [31:0] pick_ext;

  assign out_free = !out_valid_q || out_ready_i;
  assign set_ext  = 64'(set_q);
  assign pick_ext = 32'(pick_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_item_q.outcome        <= outcome_q;
      out_item_q.set_index      <= set_ext[9:0];
      out_item_q.way_used       <= pick_ext[2:0];
      out_item_q.hit_total      <= hits_d;
      out_item_q.miss_total     <= misses_d;
      out_item_q.eviction_total <= evicts_d;
      out_item_q.last           <= !(modify_q && !second_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // status to the controller
  assign status_o.clear_last = clear_last;
  assign status_o.in_noop    = (command_e'(in_item_i.command) == CMD_NONE);
  assign status_o.out_free   = out_free;
  assign status_o.more       = modify_q && !second_q;

endmodule

/* rtl/lru_set_assoc_cache_lookup.sv */
// top level of the lru set-associative cache tag store
// After reset the block sweeps its set row memory to clear the valid bits, one set
// per cycle, and takes no item meanwhile (config writes still land). Each lookup
// reads a whole set row from memory, evaluates hit, free way and oldest stamp in the
// next cycle, and then, once the result register is free, writes the row back while
// loading the result register. A modify does a second read, evaluate and write-back
// on the same address; an unused command is taken without a lookup. The three-step
// read, evaluate, write-back loop through the row memory means a new item is taken
// only once the last one is written back.
module lru_set_assoc_cache_lookup
  import lrucache_pkg::*;
#(
  parameter int MAX_SETS = MaxSetsDef,
  parameter int MAX_WAYS = MaxWaysDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [5:0] cfg_wdata_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // sequencer
  lrucache_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath
  lrucache_dp #(
    .MAX_SETS (MAX_SETS),
    .MAX_WAYS (MAX_WAYS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

/* tb/sv/tb_top.sv */
// self-checking testbench for the lru set-associative cache tag store
`timescale 1ns / 100ps

module tb_top;
  import lrucache_pkg::*;

  localparam int SetBitsCap = $clog2(MaxSetsDef + 1) - 1;
  localparam int LineCount  = MaxSetsDef * MaxWaysDef;
  localparam int HoldCycles = 400;
  localparam int SettlePad  = 16;
  localparam int DrainBound = 100000;
  localparam int RandPhases = 10;
  localparam int PhaseItems = 140;

  // dut ports
  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [1:0] cfg_index_i = CFG_SET_BITS;
  logic [5:0] cfg_wdata_i = '0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  in_item_t   in_item_i   = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_item_t  out_item_o;

  // stimulus control
  in_item_t   access_queue[$];
  out_item_t  lookups_due[$];
  logic       calm_mode   = 1'b0;
  logic       hold_req    = 1'b0;
  int         hold_left   = 0;
  int         tx_gap_left = 0;
  int         rx_gap_left = 0;

  // predicted tag store
  logic [3:0]  cfg_set_bits    = '0;
  logic [5:0]  cfg_offset_bits = '0;
  logic [3:0]  cfg_ways        = 4'd1;
  bit          line_ok   [LineCount];
  logic [63:0] line_tag  [LineCount];
  logic [31:0] line_stamp[LineCount];
  logic [31:0] use_clock   = '0;
  logic [31:0] hits_seen   = '0;
  logic [31:0] misses_seen = '0;
  logic [31:0] evicts_seen = '0;

  // bookkeeping
  int          mismatches    = 0;
  int          accesses_done = 0;
  int          lookups_done  = 0;
  int          settings_run  = 0;
  logic [63:0] tag_pool[12];
  logic [63:0] last_addr     = '0;

  lru_set_assoc_cache_lookup dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // 50 MHz clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int eff_set_bits();
    return (int'(cfg_set_bits) > SetBitsCap) ? SetBitsCap : int'(cfg_set_bits);
  endfunction

  function automatic int eff_ways();
    if (cfg_ways == 4'd0) return 1;
    return (int'(cfg_ways) > MaxWaysDef) ? MaxWaysDef : int'(cfg_ways);
  endfunction

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // one lookup against the predicted tag store, queues the expected result
  function automatic void tag_store_lookup(logic [63:0] addr, logic fin);
    int          sb;
    int          nways;
    int          base;
    int          pick;
    logic [63:0] set_no;
    logic [63:0] tag_v;
    out_item_t   r;
    sb     = eff_set_bits();
    nways  = eff_ways();
    set_no = (addr >> cfg_offset_bits) & ((64'd1 << sb) - 64'd1);
    tag_v  = addr >> (int'(cfg_offset_bits) + sb);
    base   = int'(set_no) * MaxWaysDef;
    r      = '0;
    pick   = nways;
    for (int w = 0; w < nways; w++) begin
      if (pick == nways && line_ok[base + w] && line_tag[base + w] == tag_v) pick = w;
    end
    if (pick < nways) begin
      r.outcome = OUT_HIT;
      hits_seen = sat_inc(hits_seen);
    end else begin
      misses_seen = sat_inc(misses_seen);
      for (int w = 0; w < nways; w++) begin
        if (pick == nways && !line_ok[base + w]) pick = w;
      end
      if (pick < nways) begin
        r.outcome = OUT_FILL;
      end else begin
        // oldest stamp goes, lowest way wins a tie
        r.outcome   = OUT_EVICT;
        evicts_seen = sat_inc(evicts_seen);
        pick        = 0;
        for (int w = 1; w < nways; w++) begin
          if (line_stamp[base + w] < line_stamp[base + pick]) pick = w;
        end
      end
      line_ok[base + pick]  = 1'b1;
      line_tag[base + pick] = tag_v;
    end
    use_clock              = use_clock + 32'd1;
    line_stamp[base + pick] = use_clock;
    r.set_index      = set_no[9:0];
    r.way_used       = 3'(pick);
    r.hit_total      = hits_seen;
    r.miss_total     = misses_seen;
    r.eviction_total = evicts_seen;
    r.last           = fin;
    lookups_due.push_back(r);
  endfunction

  // a modify looks up twice, the unused command not at all
  function automatic void predict_access(in_item_t it);
    case (command_e'(it.command))
      CMD_MODIFY: begin
        tag_store_lookup(it.address, 1'b0);
        tag_store_lookup(it.address, 1'b1);
      end
      CMD_LOAD, CMD_STORE: tag_store_lookup(it.address, 1'b1);
      default: ;
    endcase
  endfunction

  // mostly short gaps, a few long ones
  function automatic int draw_gap(logic calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // driver: offers queued items, keeps valid and payload until taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      in_item_i   <= '0;
      tx_gap_left <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_access(in_item_i);
        accesses_done++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (tx_gap_left != 0) begin
          tx_gap_left <= tx_gap_left - 1;
          in_valid_i  <= 1'b0;
        end else if (access_queue.size() != 0) begin
          in_item_i   <= access_queue.pop_front();
          in_valid_i  <= 1'b1;
          tx_gap_left <= draw_gap(calm_mode);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_req && hold_left == 0) begin
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: checks each result against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_r;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_gap_left <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        lookups_done++;
        if (lookups_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("error: unexpected result %h at %0t", out_item_o, $realtime);
        end else begin
          exp_r = lookups_due.pop_front();
          if (out_item_o.outcome !== exp_r.outcome ||
              out_item_o.set_index !== exp_r.set_index ||
              out_item_o.way_used !== exp_r.way_used ||
              out_item_o.hit_total !== exp_r.hit_total ||
              out_item_o.miss_total !== exp_r.miss_total ||
              out_item_o.eviction_total !== exp_r.eviction_total ||
              out_item_o.last !== exp_r.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("error: lookup %0d at %0t", lookups_done, $realtime);
              $display("  exp outcome=%0d set=%0d way=%0d hits=%0d misses=%0d evicts=%0d last=%0b",
                       exp_r.outcome, exp_r.set_index, exp_r.way_used, exp_r.hit_total,
                       exp_r.miss_total, exp_r.eviction_total, exp_r.last);
              $display("  got outcome=%0d set=%0d way=%0d hits=%0d misses=%0d evicts=%0d last=%0b",
                       out_item_o.outcome, out_item_o.set_index, out_item_o.way_used,
                       out_item_o.hit_total, out_item_o.miss_total,
                       out_item_o.eviction_total, out_item_o.last);
            end
          end
        end
      end
      // ready: forced low during a hold, otherwise random stalls
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
      end else if (rx_gap_left != 0) begin
        rx_gap_left <= rx_gap_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        rx_gap_left <= draw_gap(calm_mode);
        out_ready_i <= 1'b1;
      end
    end
  end

  // register write, mirrored in the predictor when it lands
  task automatic write_reg(logic [1:0] idx, logic [5:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SET_BITS:    cfg_set_bits    = val[3:0];
      CFG_OFFSET_BITS: cfg_offset_bits = val;
      CFG_WAYS:        cfg_ways        = val[3:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(logic [5:0] sb, logic [5:0] off, logic [5:0] ways);
    write_reg(CFG_SET_BITS, sb);
    write_reg(CFG_OFFSET_BITS, off);
    write_reg(CFG_WAYS, ways);
    settings_run++;
  endtask

  task automatic queue_item(command_e c, logic [63:0] a);
    in_item_t it;
    it.command = c;
    it.address = a;
    access_queue.push_back(it);
  endtask

  // wait until every item is taken and every result has come, then settle
  task automatic wait_drain();
    int cycles;
    cycles = 0;
    @(negedge clk_i);
    while ((access_queue.size() != 0 || in_valid_i || lookups_due.size() != 0) &&
           cycles < DrainBound) begin
      @(negedge clk_i);
      cycles++;
    end
    if (lookups_due.size() != 0) begin
      $display("error: %0d results never arrived", lookups_due.size());
      mismatches += lookups_due.size();
      lookups_due.delete();
    end
    repeat (SettlePad) @(posedge clk_i);
  endtask

  // address from a small tag pool so sets fill up and evict
  function automatic logic [63:0] make_address();
    int          r;
    int          sb;
    int          off;
    logic [63:0] tag_v;
    logic [63:0] set_no;
    logic [63:0] low;
    sb  = eff_set_bits();
    off = int'(cfg_offset_bits);
    r   = $urandom_range(0, 99);
    if (r < 15) return {$urandom, $urandom};
    if (r < 25) return last_addr;
    tag_v  = tag_pool[$urandom_range(0, eff_ways() + 1)];
    set_no = 64'($urandom_range(0, (1 << sb) - 1));
    low    = {$urandom, $urandom} & ((64'd1 << off) - 64'd1);
    return (tag_v << (off + sb)) | (set_no << off) | low;
  endfunction

  function automatic command_e pick_command();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return CMD_LOAD;
    if (r < 65) return CMD_STORE;
    if (r < 90) return CMD_MODIFY;
    return CMD_NONE;
  endfunction

  // main sequence
  initial begin
    int       taken;
    command_e c;
    for (int i = 0; i < LineCount; i++) begin
      line_ok[i]    = 1'b0;
      line_tag[i]   = '0;
      line_stamp[i] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // one way, one set: fill, hit, evict, modify, unused command
    set_geometry(6'd0, 6'd0, 6'd1);
    @(negedge clk_i);
    queue_item(CMD_LOAD, 64'd0);
    queue_item(CMD_LOAD, 64'd0);
    queue_item(CMD_STORE, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_item(CMD_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_item(CMD_MODIFY, 64'd0);
    queue_item(CMD_NONE, 64'h5555_5555_5555_5555);
    queue_item(CMD_LOAD, 64'h8000_0000_0000_0000);
    wait_drain();

    // set bits clamped, offset 63, zero ways acts as one
    set_geometry(6'd15, 6'd63, 6'd0);
    @(negedge clk_i);
    queue_item(CMD_LOAD, 64'd0);
    queue_item(CMD_LOAD, 64'h8000_0000_0000_0000);
    queue_item(CMD_STORE, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_item(CMD_MODIFY, 64'h7FFF_FFFF_FFFF_FFFF);
    queue_item(CMD_NONE, 64'hAAAA_AAAA_AAAA_AAAA);
    wait_drain();

    // all sets, tag shifted out entirely, too many ways acts as the maximum
    set_geometry(6'd10, 6'd54, 6'd15);
    @(negedge clk_i);
    queue_item(CMD_LOAD, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_item(CMD_LOAD, 64'h003F_FFFF_FFFF_FFFF);
    queue_item(CMD_MODIFY, 64'hFFC0_0000_0000_0000);
    queue_item(CMD_STORE, 64'h0040_0000_0000_0000);
    queue_item(CMD_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
    wait_drain();

    // random phases, lines kept across register changes
    for (int ph = 0; ph < RandPhases; ph++) begin
      set_geometry((ph % 3 == 0) ? 6'($urandom_range(0, 15)) : 6'($urandom_range(0, 4)),
                   (ph % 4 == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 8)),
                   (ph == 1) ? 6'd8 :
                   (ph % 3 == 1) ? 6'($urandom_range(0, 15)) : 6'($urandom_range(1, 4)));
      for (int i = 0; i < 12; i++) tag_pool[i] = (i < 2) ? 64'(i) : {$urandom, $urandom};
      @(posedge clk_i);
      calm_mode <= (ph == 4);
      @(negedge clk_i);
      taken = 0;
      while (taken < PhaseItems) begin
        c         = pick_command();
        last_addr = make_address();
        queue_item(c, last_addr);
        if (c != CMD_NONE) taken++;
      end
      // receiver holds off while the sender keeps offering
      if (ph == 2) begin
        @(posedge clk_i);
        hold_req <= 1'b1;
        @(posedge clk_i);
        hold_req <= 1'b0;
      end
      wait_drain();
    end

    $display("run covered %0d accesses and %0d lookups over %0d register settings",
             accesses_done, lookups_done, settings_run);
    $display("predicted %0d hits, %0d misses, %0d evictions",
             hits_seen, misses_seen, evicts_seen);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #30_000_000;
    $display("error: timeout with %0d results outstanding", lookups_due.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
